// ----- hdl/beacon_power_sweep_scheduler_unit_assert.svh -----
// assertion macros for the beacon power sweep scheduler
`ifndef BEACON_POWER_SWEEP_SCHEDULER_UNIT_ASSERT_SVH
`define BEACON_POWER_SWEEP_SCHEDULER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BPSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BPSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bpss_pkg.sv -----
package bpss_pkg;

  // timer counters
  localparam int unsigned TimerWidth = 16;
  localparam logic [32:0] TimerMaxWide = (33'd1 << TimerWidth) - 33'd1;
  typedef logic [TimerWidth-1:0] timer_t;

  // configuration address
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  // sweep phase, one-hot
  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhSlot = 3'b010,
    PhRest = 3'b100
  } phase_e;

  // register index
  typedef enum logic [2:0] {
    RegEnable  = 3'd0,
    RegLevels  = 3'd1,
    RegMajor   = 3'd2,
    RegMinor   = 3'd3,
    RegRxLevel = 3'd4,
    RegRxSpan  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic        enable;
    logic [15:0] levels;
    logic [15:0] major;
    logic [15:0] minor;
    logic [3:0]  rx_level;
    logic [15:0] rx_span;
  } cfg_t;

  typedef struct packed {
    logic       send_beacon;
    logic [3:0] beacon_level;
    logic [7:0] tx_power;
    logic       rx_flag;
    logic       rx_enable;
  } result_t;

  // level to radio power setting
  localparam logic [7:0] PowerMap [16] = '{
    8'h01, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h0A,
    8'h0F, 8'h60, 8'h70, 8'h80, 8'h90, 8'hC0, 8'hE0, 8'hFF
  };

  localparam logic [15:0] NibbleMask = 16'h000F;

  // clamp a loaded count to the timer range
  function automatic timer_t sat_timer(input logic [17:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w > TimerMaxWide) begin
      return TimerWidth'(TimerMaxWide);
    end
    return TimerWidth'(w);
  endfunction

endpackage

// ----- hdl/bpss_tick_if.sv -----
interface bpss_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

// ----- hdl/bpss_beacon_if.sv -----
interface bpss_beacon_if;
  logic       valid;
  logic       ready;
  logic       send_beacon;
  logic [3:0] beacon_level;
  logic [7:0] tx_power;
  logic       rx_flag;
  logic       rx_enable;

  modport source (
    output valid, output send_beacon, output beacon_level, output tx_power,
    output rx_flag, output rx_enable, input ready
  );
  modport sink (
    input valid, input send_beacon, input beacon_level, input tx_power,
    input rx_flag, input rx_enable, output ready
  );
endinterface

// ----- hdl/bpss_apb_regs.sv -----
module bpss_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpss_pkg::AddrWidth-1:0] paddr,
  input  logic [bpss_pkg::DataWidth-1:0] pwdata,
  output logic [bpss_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  output bpss_pkg::cfg_t                 cfg_o
);

  bpss_pkg::cfg_t     cfg_q;
  bpss_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = bpss_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        bpss_pkg::RegEnable:  cfg_q.enable   <= pwdata[0];
        bpss_pkg::RegLevels:  cfg_q.levels   <= pwdata[15:0];
        bpss_pkg::RegMajor:   cfg_q.major    <= pwdata[15:0];
        bpss_pkg::RegMinor:   cfg_q.minor    <= pwdata[15:0];
        bpss_pkg::RegRxLevel: cfg_q.rx_level <= pwdata[3:0];
        bpss_pkg::RegRxSpan:  cfg_q.rx_span  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      bpss_pkg::RegEnable:  prdata = 32'(cfg_q.enable);
      bpss_pkg::RegLevels:  prdata = 32'(cfg_q.levels);
      bpss_pkg::RegMajor:   prdata = 32'(cfg_q.major);
      bpss_pkg::RegMinor:   prdata = 32'(cfg_q.minor);
      bpss_pkg::RegRxLevel: prdata = 32'(cfg_q.rx_level);
      bpss_pkg::RegRxSpan:  prdata = 32'(cfg_q.rx_span);
      default:              prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/bpss_sweep.sv -----
module bpss_sweep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpss_pkg::cfg_t    cfg_i,
  input  logic              step_i,
  input  logic              tick_i,
  output bpss_pkg::result_t res_o
);

  bpss_pkg::phase_e phase_q, phase_d;
  logic [1:0]       slot_q, slot_d;
  bpss_pkg::timer_t wait_q, wait_d;
  bpss_pkg::timer_t rem_q, rem_d;
  logic             open_q, open_d;

  logic             fire;
  logic [1:0]       fire_slot;
  logic [3:0]       level;
  logic [17:0]      used;
  logic [17:0]      major_ext;

  assign used      = {cfg_i.minor, 2'b00};
  assign major_ext = {2'b00, cfg_i.major};

  // next state and result for one item
  always_comb begin
    phase_d   = phase_q;
    slot_d    = slot_q;
    wait_d    = wait_q;
    rem_d     = rem_q;
    open_d    = open_q;
    res_o     = '0;
    fire      = 1'b0;
    fire_slot = slot_q;
    level     = '0;

    if (step_i && tick_i) begin
      // receive window counts down first
      if (open_q) begin
        if (rem_q != '0) begin
          rem_d = rem_q - 1'b1;
        end
        if (rem_d == '0) begin
          open_d = 1'b0;
        end
      end

      // sweep sequencing
      if (!cfg_i.enable || cfg_i.major < 16'd2) begin
        phase_d = bpss_pkg::PhIdle;
        slot_d  = '0;
        wait_d  = '0;
      end else if (phase_q == bpss_pkg::PhIdle) begin
        fire      = 1'b1;
        fire_slot = '0;
      end else if (wait_q > bpss_pkg::TimerWidth'(1)) begin
        wait_d = wait_q - 1'b1;
      end else if (phase_q == bpss_pkg::PhSlot && slot_q != 2'd3) begin
        fire      = 1'b1;
        fire_slot = slot_q + 2'd1;
      end else if (phase_q == bpss_pkg::PhSlot && major_ext > used) begin
        phase_d = bpss_pkg::PhRest;
        wait_d  = bpss_pkg::sat_timer(major_ext - used);
        slot_d  = '0;
      end else begin
        fire      = 1'b1;
        fire_slot = '0;
      end

      // slot event
      if (fire) begin
        level   = 4'((cfg_i.levels >> {fire_slot, 2'b00}) & bpss_pkg::NibbleMask);
        slot_d  = fire_slot;
        phase_d = bpss_pkg::PhSlot;
        wait_d  = bpss_pkg::sat_timer({2'b00, cfg_i.minor});
        if (level != '0) begin
          res_o.send_beacon  = 1'b1;
          res_o.beacon_level = level;
          res_o.tx_power     = bpss_pkg::PowerMap[level];
          if (level == cfg_i.rx_level) begin
            res_o.rx_flag = 1'b1;
            if (!open_d && cfg_i.rx_span != '0) begin
              open_d = 1'b1;
              rem_d  = bpss_pkg::sat_timer({2'b00, cfg_i.rx_span});
            end
          end
        end
      end
    end

    res_o.rx_enable = open_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bpss_pkg::PhIdle;
      slot_q  <= '0;
      wait_q  <= '0;
      rem_q   <= '0;
      open_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      slot_q  <= slot_d;
      wait_q  <= wait_d;
      rem_q   <= rem_d;
      open_q  <= open_d;
    end
  end

endmodule

// ----- hdl/beacon_power_sweep_scheduler_unit.sv -----
// Beacon power sweep scheduler.
// Input channel tick_chan_i carries one timer tick per item; tick = 0 only
// samples the receive window and changes no state. Output channel
// beacon_chan_o returns exactly one item per input item, in order, with the
// beacon fields of that tick and the receive window state after it.
// Configuration is written through the APB-style port (psel/penable/...),
// registers at byte address 4*i; write only while no item is in flight.
// An accepted item is held in the input register; its result is computed
// combinationally and loaded into the result register once that register
// is free, and it is offered on beacon_chan_o from there.
// Throughput: one item per cycle while the receiver takes every result, set by
// the combinational step between the input register and the result register.
// When the receiver stalls, the result register holds its item and the
// input register takes one more item; after that ready drops until the
// result is taken. Neither side waits on the other otherwise.
// Reset (rst_ni low, asynchronous) clears the configuration to zero, empties
// both registers, returns the sweep to idle at slot 0 and closes the window.
`include "beacon_power_sweep_scheduler_unit_assert.svh"

module beacon_power_sweep_scheduler_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bpss_tick_if.sink                      tick_chan_i,
  bpss_beacon_if.source                  beacon_chan_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpss_pkg::AddrWidth-1:0] paddr,
  input  logic [bpss_pkg::DataWidth-1:0] pwdata,
  output logic [bpss_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);

  bpss_pkg::cfg_t    cfg;
  bpss_pkg::result_t step_res;
  bpss_pkg::result_t out_q;
  logic              in_valid_q;
  logic              in_tick_q;
  logic              out_valid_q;
  logic              out_free;
  logic              advance;
  logic              in_ready;

  // configuration registers
  bpss_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake between the two registers
  assign out_free = !out_valid_q || beacon_chan_o.ready;
  assign advance  = in_valid_q && out_free;
  assign in_ready = !in_valid_q || advance;
  assign tick_chan_i.ready = in_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= tick_chan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && tick_chan_i.valid) begin
      in_tick_q <= tick_chan_i.tick;
    end
  end

  // sweep state and per-item step
  bpss_sweep u_sweep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .tick_i (in_tick_q),
    .res_o  (step_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign beacon_chan_o.valid        = out_valid_q;
  assign beacon_chan_o.send_beacon  = out_q.send_beacon;
  assign beacon_chan_o.beacon_level = out_q.beacon_level;
  assign beacon_chan_o.tx_power     = out_q.tx_power;
  assign beacon_chan_o.rx_flag      = out_q.rx_flag;
  assign beacon_chan_o.rx_enable    = out_q.rx_enable;

  // checks
  `BPSS_ASSERT_SAME(a_quiet_fields, clk_i, rst_ni, out_valid_q && !out_q.send_beacon, out_q.beacon_level == 4'd0 && out_q.tx_power == 8'd0, "beacon fields set without a beacon")
  `BPSS_ASSERT_SAME(a_flag_needs_beacon, clk_i, rst_ni, out_valid_q && out_q.rx_flag, out_q.send_beacon, "receive flag without a beacon")
  `BPSS_ASSERT_SAME(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, tick_chan_i.ready, "input stalled with empty result register")
  `BPSS_ASSERT_NEXT(a_item_reaches_out, clk_i, rst_ni, advance, out_valid_q, "item lost between input and result register")

endmodule

// ----- dv/beacon_sweep_check.sv -----
module beacon_sweep_check
  import bpss_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bpss_tick_if                 tick_mon_i,
  bpss_beacon_if               beacon_mon_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [AddrWidth-1:0] paddr_i,
  input  logic [DataWidth-1:0] pwdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  // radio power setting per beacon level
  localparam logic [7:0] RadioPower [16] = '{
    8'h01, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h0A,
    8'h0F, 8'h60, 8'h70, 8'h80, 8'h90, 8'hC0, 8'hE0, 8'hFF
  };

  // shadow of the registers and the sweep state
  cfg_t       cfg;
  phase_e     phase;
  logic [1:0] slot_idx;
  timer_t     wait_cnt;
  timer_t     rx_left;
  logic       rx_on;

  result_t pending_beacons[$];
  result_t want;
  int      mismatch_cnt = 0;

  assign fail_count_o = mismatch_cnt;

  // one timer tick of the sweep, returns the beacon item it produces
  function automatic result_t advance_sweep(logic tick);
    result_t     r;
    logic        fire;
    logic [3:0]  lvl;
    logic [17:0] used;
    logic [17:0] diff;
    r = '0;
    fire = 1'b0;
    if (tick) begin
      // window counts down before any new trigger
      if (rx_on) begin
        if (rx_left != '0) begin
          rx_left = rx_left - 1'b1;
        end
        if (rx_left == '0) begin
          rx_on = 1'b0;
        end
      end
      if (!cfg.enable || cfg.major < 16'd2) begin
        phase = PhIdle;
        slot_idx = '0;
        wait_cnt = '0;
      end else if (phase == PhIdle) begin
        slot_idx = '0;
        fire = 1'b1;
      end else if (wait_cnt > timer_t'(1)) begin
        wait_cnt = wait_cnt - 1'b1;
      end else if (phase == PhSlot && slot_idx < 2'd3) begin
        slot_idx = slot_idx + 1'b1;
        fire = 1'b1;
      end else if (phase == PhSlot) begin
        // after the last slot: rest out the major period if any is left
        used = {cfg.minor, 2'b00};
        slot_idx = '0;
        if ({2'b00, cfg.major} > used) begin
          diff = {2'b00, cfg.major} - used;
          phase = PhRest;
          wait_cnt = (diff[17:16] != 2'b00) ? '1 : diff[15:0];
        end else begin
          fire = 1'b1;
        end
      end else begin
        slot_idx = '0;
        fire = 1'b1;
      end
      // slot event: beacon if the level is nonzero, maybe open the window
      if (fire) begin
        lvl = cfg.levels[slot_idx*4 +: 4];
        if (lvl != 4'd0) begin
          r.send_beacon = 1'b1;
          r.beacon_level = lvl;
          r.tx_power = RadioPower[lvl];
          if (lvl == cfg.rx_level) begin
            r.rx_flag = 1'b1;
            if (!rx_on && cfg.rx_span != '0) begin
              rx_on = 1'b1;
              rx_left = cfg.rx_span;
            end
          end
        end
        phase = PhSlot;
        wait_cnt = cfg.minor;
      end
    end
    r.rx_enable = rx_on;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatch_cnt++;
    end
  endfunction

  // compare results, track register writes, predict accepted ticks
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '0;
      phase = PhIdle;
      slot_idx = '0;
      wait_cnt = '0;
      rx_left = '0;
      rx_on = 1'b0;
      pending_beacons.delete();
      pending_o <= 0;
    end else begin
      if (beacon_mon_i.valid && beacon_mon_i.ready) begin
        if (pending_beacons.size() == 0) begin
          $error("beacon item with no tick waiting for it");
          mismatch_cnt++;
        end else begin
          want = pending_beacons.pop_front();
          check_field("send_beacon", want.send_beacon, beacon_mon_i.send_beacon);
          check_field("beacon_level", want.beacon_level, beacon_mon_i.beacon_level);
          check_field("tx_power", want.tx_power, beacon_mon_i.tx_power);
          check_field("rx_flag", want.rx_flag, beacon_mon_i.rx_flag);
          check_field("rx_enable", want.rx_enable, beacon_mon_i.rx_enable);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[AddrWidth-1:2]))
          RegEnable: begin
            cfg.enable = pwdata_i[0];
          end
          RegLevels: begin
            cfg.levels = pwdata_i[15:0];
          end
          RegMajor: begin
            cfg.major = pwdata_i[15:0];
          end
          RegMinor: begin
            cfg.minor = pwdata_i[15:0];
          end
          RegRxLevel: begin
            cfg.rx_level = pwdata_i[3:0];
          end
          RegRxSpan: begin
            cfg.rx_span = pwdata_i[15:0];
          end
          default: begin
          end
        endcase
      end
      if (tick_mon_i.valid && tick_mon_i.ready) begin
        pending_beacons.push_back(advance_sweep(tick_mon_i.tick));
      end
      pending_o <= pending_beacons.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
module testbench;
  import bpss_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  int fail_count;
  int pending;
  int src_idle = 36;
  int sink_idle = 83;
  int hold_cycles = 0;

  bpss_tick_if   tick_chan ();
  bpss_beacon_if beacon_chan ();

  beacon_power_sweep_scheduler_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_chan_i   (tick_chan),
    .beacon_chan_o (beacon_chan),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  beacon_sweep_check u_sweep_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_mon_i   (tick_chan),
    .beacon_mon_i (beacon_chan),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // result side: random stalls, or a long counted hold-off when asked
  initial begin
    beacon_chan.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        beacon_chan.ready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        beacon_chan.ready <= ($urandom_range(99) >= sink_idle);
      end
    end
  end

  // register write: setup cycle, then access cycle
  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // offer one tick item after a random gap, return once it is taken
  task automatic send_tick(logic t);
    while ($urandom_range(99) < src_idle) begin
      tick_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_chan.valid <= 1'b1;
    tick_chan.tick <= t;
    @(posedge clk_i);
    while (!tick_chan.ready) begin
      @(posedge clk_i);
    end
  endtask

  // send n ticks, tick value from the low bits of pat
  task automatic send_pattern(int n, logic [31:0] pat);
    for (int i = 0; i < n; i++) begin
      send_tick(pat[i]);
    end
  endtask

  // stop offering and wait until every beacon item is back
  task automatic settle();
    tick_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  // full register setup while the block is idle
  task automatic load_config(logic en, logic [15:0] lv, logic [15:0] mj, logic [15:0] mn,
                             logic [3:0] rl, logic [15:0] sp);
    settle();
    reg_write(RegEnable, 32'(en));
    reg_write(RegLevels, 32'(lv));
    reg_write(RegMajor, 32'(mj));
    reg_write(RegMinor, 32'(mn));
    reg_write(RegRxLevel, 32'(rl));
    reg_write(RegRxSpan, 32'(sp));
  endtask

  initial begin
    logic        en;
    logic [15:0] lv;
    logic [15:0] mj;
    logic [15:0] mn;
    logic [3:0]  rl;
    logic [15:0] sp;
    int          saved_idle;

    rst_ni <= 1'b0;
    tick_chan.valid <= 1'b0;
    tick_chan.tick <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sweep stopped at reset values, with a sample tick in between
    send_pattern(3, 32'b101);
    // back-to-back slots, skipped slot, short window, rest of period
    load_config(1'b1, 16'h3F01, 16'd2, 16'd0, 4'd1, 16'd2);
    send_pattern(8, 32'b11111011);
    // no rest, window closes and reopens on the same tick
    load_config(1'b1, 16'h7777, 16'd8, 16'd2, 4'd7, 16'd2);
    send_pattern(7, 32'b1110111);
    // all fields at their maximum
    load_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF);
    send_pattern(2, 32'b11);
    // disabled
    load_config(1'b0, 16'hA5C3, 16'd9, 16'd1, 4'd3, 16'd0);
    send_tick(1'b1);
    // receive level zero against a zero nibble
    load_config(1'b1, 16'h0A05, 16'd5, 16'd1, 4'd0, 16'd3);
    send_pattern(3, 32'b111);

    // random settings under three idling mixes
    for (int stage = 0; stage < 3; stage++) begin
      settle();
      case (stage)
        0: begin
          src_idle = 36;
          sink_idle = 83;
        end
        1: begin
          src_idle = 83;
          sink_idle = 36;
        end
        default: begin
          src_idle = 0;
          sink_idle = 0;
        end
      endcase
      for (int burst = 0; burst < 10; burst++) begin
        en = ($urandom_range(9) != 0);
        lv = 16'($urandom_range(65535));
        case ($urandom_range(9))
          0: mj = 16'($urandom_range(1));
          1: mj = 16'hFFFF;
          default: mj = 16'($urandom_range(40, 2));
        endcase
        case ($urandom_range(9))
          0: mn = 16'd0;
          1: mn = 16'hFFFF;
          default: mn = 16'($urandom_range(8, 1));
        endcase
        if ($urandom_range(3) == 0) begin
          rl = 4'($urandom_range(15));
        end else begin
          rl = lv[4*$urandom_range(3) +: 4];
        end
        case ($urandom_range(9))
          0: sp = 16'd0;
          1: sp = 16'hFFFF;
          default: sp = 16'($urandom_range(20, 1));
        endcase
        load_config(en, lv, mj, mn, rl, sp);
        repeat (62) send_tick($urandom_range(7) != 0);
        // receiver holds off while ticks keep coming
        if (burst == 4) begin
          saved_idle = src_idle;
          src_idle = 0;
          hold_cycles <= 60;
          repeat (24) send_tick(1'b1);
          src_idle = saved_idle;
          settle();
        end
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("beacon_power_sweep_scheduler_unit regression: pass");
    end else begin
      $display("beacon_power_sweep_scheduler_unit regression: fail");
    end
    $finish;
  end

  // hang guard
  initial begin
    #1600000;
    $display("beacon_power_sweep_scheduler_unit regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bpss_pkg.sv
hdl/bpss_tick_if.sv
hdl/bpss_beacon_if.sv
hdl/bpss_apb_regs.sv
hdl/bpss_sweep.sv
hdl/beacon_power_sweep_scheduler_unit.sv
dv/beacon_sweep_check.sv
dv/testbench.sv
